[rtl/clf_pkg.sv]
package clf_pkg;

    // Request kinds, carried on s_tuser
    typedef enum logic [2:0] {
        FUNC_INIT     = 3'd0,
        FUNC_RAW_CMD  = 3'd1,
        FUNC_RAW_DATA = 3'd2,
        FUNC_CHAR     = 3'd3,
        FUNC_UDEC     = 3'd4,
        FUNC_SDEC     = 3'd5,
        FUNC_HEX      = 3'd6,
        FUNC_BIN      = 3'd7
    } func_t;

    typedef enum logic [1:0] {
        BASE_DEC,
        BASE_HEX,
        BASE_BIN
    } base_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_RAW,
        S_CALC,
        S_CURSOR,
        S_CHAR,
        S_SIGN,
        S_DIGIT
    } state_t;

    localparam logic       RS_CMD  = 1'b0;
    localparam logic       RS_DATA = 1'b1;

    localparam logic [7:0] CMD_FUNC_SET   = 8'h38;
    localparam logic [7:0] CMD_DISP_ON    = 8'h0C;
    localparam logic [7:0] CMD_ENTRY_MODE = 8'h06;
    localparam logic [7:0] CMD_CLEAR      = 8'h01;
    localparam logic [7:0] CMD_SET_DDRAM  = 8'h80;
    localparam logic [7:0] ROW2_OFFSET    = 8'h40;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_A     = 8'h41;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    // x / 10 == (x * 52429) >> 19 for every x below 81920
    localparam logic [16:0] DEC_RECIP = 17'd52429;
    localparam int          DEC_SHIFT = 19;

    localparam logic [1:0] INIT_LAST = 2'd3;

    function automatic logic [7:0] init_cmd(input logic [1:0] idx);
        logic [7:0] b;
        unique case (idx)
            2'd0:    b = CMD_FUNC_SET;
            2'd1:    b = CMD_DISP_ON;
            2'd2:    b = CMD_ENTRY_MODE;
            default: b = CMD_CLEAR;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] digit_char(input logic [3:0] d);
        logic [7:0] c;
        if (d < 4'd10) begin
            c = CHAR_ZERO + {4'd0, d};
        end else begin
            c = CHAR_A + {4'd0, d} - 8'd10;
        end
        return c;
    endfunction

endpackage

[rtl/clf_digit_unit.sv]
module clf_digit_unit (
    input  logic [15:0]         mag,
    input  clf_pkg::base_t      base,
    output logic [15:0]         quot,
    output logic [3:0]          digit
);
    import clf_pkg::*;

    logic [33:0] prod;
    logic [13:0] q_dec;
    logic [16:0] q_times10;
    logic [16:0] rem_dec;

    // divide by ten through the reciprocal; remainder by shift-add back-multiply
    assign prod      = {1'b0, mag} * DEC_RECIP;
    assign q_dec     = prod[DEC_SHIFT +: 14];
    assign q_times10 = {q_dec, 3'b000} + {2'b00, q_dec, 1'b0};
    assign rem_dec   = {1'b0, mag} - q_times10;

    always_comb begin
        unique case (base)
            BASE_HEX: begin
                quot  = {4'd0, mag[15:4]};
                digit = mag[3:0];
            end
            BASE_BIN: begin
                quot  = {1'b0, mag[15:1]};
                digit = {3'd0, mag[0]};
            end
            default: begin
                quot  = {2'd0, q_dec};
                digit = rem_dec[3:0];
            end
        endcase
    end

endmodule

[rtl/char_lcd_number_formatter_top.sv]
// Channel   Dir  tdata (low bit up)                         tuser        tlast
// s_*       in   line[1:0] column[6:2] value[22:7]          func[2:0]    -
//                length[27:23], [31:28] unused
// m_*       out  bus_byte[7:0]                              reg_select   last write
//
// One request at a time; s_tready is high only while the sequencer is idle.
// Writes per request: init four commands, raw one byte, char a cursor command and
// the character, numbers a cursor command, a sign if signed and N digits, N = digits
// printed; the single divide-by-base unit first makes one digit per cycle.
// Each write waits in the m_* register until taken; m_tready low stalls the sequencer.
// aresetn is synchronous, active low; it clears the sequencer and m_tvalid.
module char_lcd_number_formatter_top #(
    parameter int MAX_DIGITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // line[1:0], column[6:2], value[22:7], length[27:23]
    input  logic [2:0]  s_tuser,   // func[2:0]

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // bus_byte[7:0]
    output logic        m_tuser,   // reg_select
    output logic        m_tlast
);
    import clf_pkg::*;

    localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int CNT_W = $clog2(MAX_DIGITS + 1);

    // input fields
    logic [1:0]  in_line;
    logic [4:0]  in_column;
    logic [15:0] in_value;
    logic [4:0]  in_length;

    assign in_line   = s_tdata[1:0];
    assign in_column = s_tdata[6:2];
    assign in_value  = s_tdata[22:7];
    assign in_length = s_tdata[27:23];

    state_t            state_reg, state_next;
    func_t             func_reg;
    logic [7:0]        cursor_reg;
    logic [7:0]        byte_reg;
    logic              neg_reg;
    logic [15:0]       mag_reg;
    logic [CNT_W-1:0]  len_reg;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [3:0]        digs_reg [MAX_DIGITS];

    logic              m_valid_reg;
    logic [7:0]        m_byte_reg;
    logic              m_rs_reg;
    logic              m_last_reg;

    logic              accept;
    logic              out_free;
    logic              emit_go;
    logic              emit_rs;
    logic [7:0]        emit_byte;
    logic              emit_last;

    logic [7:0]        cursor_in;
    logic [CNT_W-1:0]  len_in;
    logic [15:0]       mag_in;

    base_t             base_sel;
    logic [15:0]       quot;
    logic [3:0]        digit;
    logic [CNT_W-1:0]  cnt_dec;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign cnt_dec  = cnt_reg - CNT_W'(1);

    // cursor address wraps modulo 256
    assign cursor_in = CMD_SET_DDRAM |
                       (({3'd0, in_column} - 8'd1) + ((in_line != 2'd1) ? ROW2_OFFSET : 8'd0));

    assign len_in = (int'(in_length) > MAX_DIGITS) ? CNT_W'(MAX_DIGITS)
                                                   : in_length[CNT_W-1:0];

    assign mag_in = (func_t'(s_tuser) == FUNC_SDEC && in_value[15]) ? (~in_value + 16'd1)
                                                                     : in_value;

    always_comb begin
        priority if (func_reg == FUNC_HEX) begin
            base_sel = BASE_HEX;
        end else if (func_reg == FUNC_BIN) begin
            base_sel = BASE_BIN;
        end else begin
            base_sel = BASE_DEC;
        end
    end

    clf_digit_unit u_digit (
        .mag   (mag_reg),
        .base  (base_sel),
        .quot  (quot),
        .digit (digit)
    );

    // sequencer
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        emit_go    = 1'b0;
        emit_rs    = RS_CMD;
        emit_byte  = cursor_reg;
        emit_last  = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    cnt_next = '0;
                    unique case (func_t'(s_tuser))
                        FUNC_INIT:                   state_next = S_INIT;
                        FUNC_RAW_CMD, FUNC_RAW_DATA: state_next = S_RAW;
                        FUNC_CHAR:                   state_next = S_CURSOR;
                        default: begin
                            state_next = (len_in == '0) ? S_CURSOR : S_CALC;
                        end
                    endcase
                end
            end
            S_INIT: begin
                emit_byte = init_cmd(cnt_reg[1:0]);
                emit_last = (cnt_reg[1:0] == INIT_LAST);
                if (out_free) begin
                    emit_go  = 1'b1;
                    cnt_next = cnt_reg + CNT_W'(1);
                    if (emit_last) begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_RAW: begin
                emit_rs   = (func_reg == FUNC_RAW_DATA) ? RS_DATA : RS_CMD;
                emit_byte = byte_reg;
                emit_last = 1'b1;
                if (out_free) begin
                    emit_go    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_CALC: begin
                // one digit per cycle, least significant first
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_next == len_reg) begin
                    state_next = S_CURSOR;
                end
            end
            S_CURSOR: begin
                emit_byte = cursor_reg;
                emit_last = (func_reg != FUNC_CHAR) && (func_reg != FUNC_SDEC) &&
                            (len_reg == '0);
                if (out_free) begin
                    emit_go = 1'b1;
                    priority if (func_reg == FUNC_CHAR) begin
                        state_next = S_CHAR;
                    end else if (func_reg == FUNC_SDEC) begin
                        state_next = S_SIGN;
                    end else if (len_reg == '0) begin
                        state_next = S_IDLE;
                    end else begin
                        state_next = S_DIGIT;
                    end
                end
            end
            S_CHAR: begin
                emit_rs   = RS_DATA;
                emit_byte = byte_reg;
                emit_last = 1'b1;
                if (out_free) begin
                    emit_go    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_SIGN: begin
                emit_rs   = RS_DATA;
                emit_byte = neg_reg ? CHAR_MINUS : CHAR_PLUS;
                emit_last = (len_reg == '0);
                if (out_free) begin
                    emit_go    = 1'b1;
                    state_next = emit_last ? S_IDLE : S_DIGIT;
                end
            end
            S_DIGIT: begin
                // most significant first: cnt counts down from len
                emit_rs   = RS_DATA;
                emit_byte = digit_char(digs_reg[cnt_dec[IDX_W-1:0]]);
                emit_last = (cnt_reg == CNT_W'(1));
                if (out_free) begin
                    emit_go  = 1'b1;
                    cnt_next = cnt_dec;
                    if (emit_last) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (emit_go) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // request payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            func_reg   <= func_t'(s_tuser);
            cursor_reg <= cursor_in;
            byte_reg   <= in_value[7:0];
            neg_reg    <= in_value[15];
            len_reg    <= len_in;
            mag_reg    <= mag_in;
        end else if (state_reg == S_CALC) begin
            mag_reg <= quot;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_CALC) begin
            digs_reg[cnt_reg[IDX_W-1:0]] <= digit;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_go) begin
            m_byte_reg <= emit_byte;
            m_rs_reg   <= emit_rs;
            m_last_reg <= emit_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_byte_reg;
    assign m_tuser  = m_rs_reg;
    assign m_tlast  = m_last_reg;

endmodule
